@@ rtl/clist_pkg.sv @@
// ---------------------------------------------------------------------------
// clist_pkg
// Shared field widths and operation codes for the circular list block.
// ---------------------------------------------------------------------------
package clist_pkg;

   // Width of the entry and head fields on the ports
   localparam int ENTRY_W = 4;
   // One membership bit for every value the entry field can carry
   localparam int MEMBER_N = 1 << ENTRY_W;

   // Operation codes carried on req_kind
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // Status codes carried on rsp_status
   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef logic [ENTRY_W-1:0] entry_type;

endpackage

@@ rtl/clist_link_mem.sv @@
// ---------------------------------------------------------------------------
// clist_link_mem
// One link store: synchronous memory, one write and one read port,
// read data registered.
// ---------------------------------------------------------------------------
module clist_link_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ADDR_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ADDR_W-1:0] rd_data
);

   logic [ADDR_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/circular_list_insert_remove_core.sv @@
// ---------------------------------------------------------------------------
// circular_list_insert_remove_core
// Circular doubly linked list over a fixed pool of entries. Next and prev
// links live in two synchronous memories; head, empty flag and membership
// bits live in flops.
//
//   channel  ports                                     beat taken when
//   -------  ----------------------------------------  ------------------
//   request  req_kind, req_entry                       start && !busy
//   result   rsp_head_entry, rsp_list_empty, rsp_status rsp_valid (1 cycle)
//
// Each operation runs in order: the accept edge reads the links, ST_WR1
// writes at most one entry of each link store and updates head and
// membership, ST_WR2 writes a second entry of each store for an insert
// into a non-empty list while rsp_valid is high. A new beat may be taken
// in ST_WR2, before the last is through; its reads are patched from those writes.
// Reset clears head, empty flag, membership and control; links need none.
// The receiver cannot stall, so the result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
module circular_list_insert_remove_core #(
   parameter int ENTRIES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_kind,
   input  clist_pkg::entry_type  req_entry,
   output logic                  rsp_valid,
   output clist_pkg::entry_type  rsp_head_entry,
   output logic                  rsp_list_empty,
   output logic                  rsp_status
);
   import clist_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WR1  = 2'd1;
   localparam logic [1:0] ST_WR2  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic                accept;

   // list state
   logic [IDX_W-1:0]    head_ff, head_in;
   logic                empty_ff, empty_in;
   logic [MEMBER_N-1:0] member_ff, member_in;

   // operation in flight
   logic                kind_ff;
   entry_type           entry_ff;
   logic                reject_ff, reject_in;
   logic [IDX_W-1:0]    rd_next_addr_ff, rd_next_addr;
   logic [IDX_W-1:0]    after_ff;
   logic                pair2_ff, pair2_in;

   // link memory ports
   logic                next_wr_en, prev_wr_en;
   logic [IDX_W-1:0]    next_wr_addr, next_wr_data, prev_wr_addr, prev_wr_data;
   logic [IDX_W-1:0]    next_rd_data, prev_rd_data;
   logic [IDX_W-1:0]    next_val, prev_val;

   // forwarding of the previous cycle's writes
   logic                fwd_next_en_ff, fwd_prev_en_ff;
   logic [IDX_W-1:0]    fwd_next_addr_ff, fwd_next_data_ff;
   logic [IDX_W-1:0]    fwd_prev_addr_ff, fwd_prev_data_ff;

   // result registers
   logic                rsp_valid_ff;
   entry_type           rsp_head_ff;
   logic                rsp_empty_ff, rsp_status_ff;

   logic [IDX_W-1:0]    entry_idx, req_idx;
   logic                in_range, member_hit, single;

   assign busy      = (state_ff == ST_WR1);
   assign accept    = start && !busy;
   assign req_idx   = IDX_W'(req_entry);
   assign entry_idx = IDX_W'(entry_ff);

   // accept-time checks
   assign in_range   = (32'(req_entry) < ENTRIES);
   assign member_hit = member_ff[req_entry];
   always_comb begin
      if (!in_range) begin
         reject_in = 1'b1;
      end else if (req_kind == KIND_INSERT) begin
         reject_in = member_hit;
      end else begin
         reject_in = !member_hit;
      end
   end

   // insert needs next[head], remove needs next[entry]
   assign rd_next_addr = (req_kind == KIND_INSERT) ? head_ff : req_idx;

   clist_link_mem #(.DEPTH(ENTRIES), .ADDR_W(IDX_W)) u_next_mem (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_en   (accept),
      .rd_addr (rd_next_addr),
      .rd_data (next_rd_data)
   );

   clist_link_mem #(.DEPTH(ENTRIES), .ADDR_W(IDX_W)) u_prev_mem (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (prev_rd_data)
   );

   // patch read data with a write made on the read edge
   assign next_val = (fwd_next_en_ff && fwd_next_addr_ff == rd_next_addr_ff)
                     ? fwd_next_data_ff : next_rd_data;
   assign prev_val = (fwd_prev_en_ff && fwd_prev_addr_ff == entry_idx)
                     ? fwd_prev_data_ff : prev_rd_data;
   assign single   = (next_val == entry_idx);

   // link writes
   always_comb begin
      next_wr_en   = 1'b0;
      next_wr_addr = entry_idx;
      next_wr_data = entry_idx;
      prev_wr_en   = 1'b0;
      prev_wr_addr = entry_idx;
      prev_wr_data = entry_idx;
      if (state_ff == ST_WR1 && !reject_ff) begin
         if (kind_ff == KIND_INSERT) begin
            next_wr_en = 1'b1;
            prev_wr_en = 1'b1;
            if (!empty_ff) begin
               next_wr_data = next_val;
               prev_wr_data = head_ff;
            end
         end else if (!single) begin
            // unlink: prev[n] = p, next[p] = n
            prev_wr_en   = 1'b1;
            prev_wr_addr = next_val;
            prev_wr_data = prev_val;
            next_wr_en   = 1'b1;
            next_wr_addr = prev_val;
            next_wr_data = next_val;
         end
      end else if (state_ff == ST_WR2 && pair2_ff) begin
         // splice after head: next[h] = e, prev[after] = e
         next_wr_en   = 1'b1;
         next_wr_addr = head_ff;
         prev_wr_en   = 1'b1;
         prev_wr_addr = after_ff;
      end
   end

   // head, empty and membership update
   always_comb begin
      head_in   = head_ff;
      empty_in  = empty_ff;
      member_in = member_ff;
      pair2_in  = 1'b0;
      if (state_ff == ST_WR1 && !reject_ff) begin
         if (kind_ff == KIND_INSERT) begin
            member_in[entry_ff] = 1'b1;
            if (empty_ff) begin
               head_in  = entry_idx;
               empty_in = 1'b0;
            end else begin
               pair2_in = 1'b1;
            end
         end else begin
            member_in[entry_ff] = 1'b0;
            if (single) begin
               head_in  = '0;
               empty_in = 1'b1;
            end else if (head_ff == entry_idx) begin
               head_in = next_val;
            end
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WR1;
            end
         end
         ST_WR1: begin
            state_in = ST_WR2;
         end
         ST_WR2: begin
            state_in = accept ? ST_WR1 : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         head_ff        <= '0;
         empty_ff       <= 1'b1;
         member_ff      <= '0;
         pair2_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_next_en_ff <= 1'b0;
         fwd_prev_en_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         head_ff        <= head_in;
         empty_ff       <= empty_in;
         member_ff      <= member_in;
         pair2_ff       <= pair2_in;
         rsp_valid_ff   <= (state_ff == ST_WR1);
         fwd_next_en_ff <= next_wr_en;
         fwd_prev_en_ff <= prev_wr_en;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fwd_next_addr_ff <= next_wr_addr;
      fwd_next_data_ff <= next_wr_data;
      fwd_prev_addr_ff <= prev_wr_addr;
      fwd_prev_data_ff <= prev_wr_data;
      if (accept) begin
         kind_ff         <= req_kind;
         entry_ff        <= req_entry;
         reject_ff       <= reject_in;
         rd_next_addr_ff <= rd_next_addr;
      end
      if (state_ff == ST_WR1) begin
         after_ff      <= next_val;
         rsp_head_ff   <= ENTRY_W'(head_in);
         rsp_empty_ff  <= empty_in;
         rsp_status_ff <= reject_ff ? STATUS_REJECT : STATUS_DONE;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_entry = rsp_head_ff;
   assign rsp_list_empty = rsp_empty_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
